// File: rtl/sco_pkg.sv
// shared constants and queue entry type for the sprite cell compositor
package sco_pkg;

    localparam int GLYPH_ROWS = 8;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
    localparam int PITCH_X    = 6;
    localparam int PITCH_Y    = 9;
    localparam int ROW_BITS   = 2;
    localparam int COL_BITS   = 5;

    // one classified request: flags plus the pixels it contributes to the cell
    typedef struct packed {
        logic                  first;
        logic                  last;
        logic [GLYPH_BITS-1:0] mask;
    } entry_t;

endpackage

// File: rtl/sco_front.sv
// front end: places the sprite relative to the target cell and builds its pixel mask
module sco_front #(
    parameter int MAX_CELL_COLS = 32
) (
    input  logic                              first,
    input  logic                              last,
    input  logic [sco_pkg::ROW_BITS-1:0]      cell_row,
    input  logic [sco_pkg::COL_BITS-1:0]      cell_col,
    input  logic signed [8:0]                 pos_x,
    input  logic signed [7:0]                 pos_y,
    input  logic [sco_pkg::GLYPH_BITS-1:0]    sprite_bits,
    output sco_pkg::entry_t                   entry
);
    import sco_pkg::*;

    logic [7:0]        col_org;
    logic [4:0]        row_org;
    logic signed [9:0] dx;
    logic signed [8:0] dy;
    logic              col_ok;
    logic              near;
    logic signed [3:0] dx_s;
    logic signed [3:0] dy_s;
    logic [GLYPH_BITS-1:0] mask;

    // pixel origin of the target cell
    assign col_org = 8'(cell_col) * 8'(PITCH_X);
    assign row_org = 5'(cell_row) * 5'(PITCH_Y);

    // sprite offset from the cell origin
    assign dx = $signed({pos_x[8], pos_x}) - $signed({2'b00, col_org});
    assign dy = $signed({pos_y[7], pos_y}) - $signed({4'b0000, row_org});

    assign col_ok = (int'(cell_col) < MAX_CELL_COLS);
    assign near   = (dx >= -10'sd4) && (dx <= 10'sd4) && (dy >= -9'sd7) && (dy <= 9'sd7);
    assign dx_s   = dx[3:0];
    assign dy_s   = dy[3:0];

    // each glyph pixel picks the sprite pixel that covers it, if any
    always_comb
    begin
        int ii;
        int jj;
        mask = '0;
        for (int gr = 0; gr < GLYPH_ROWS; gr++)
        begin
            for (int gc = 0; gc < GLYPH_COLS; gc++)
            begin
                ii = gr - int'(dy_s);
                jj = gc - int'(dx_s);
                if (ii >= 0 && ii < GLYPH_ROWS && jj >= 0 && jj < GLYPH_COLS)
                begin
                    mask[gr*GLYPH_COLS + GLYPH_COLS-1 - gc] =
                        sprite_bits[ii*GLYPH_COLS + GLYPH_COLS-1 - jj];
                end
            end
        end
    end

    assign entry.first = first;
    assign entry.last  = last;
    assign entry.mask  = (col_ok && near) ? mask : '0;

endmodule

// File: rtl/sco_fifo.sv
// two-entry queue between the front and back ends
module sco_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sco_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sco_pkg::entry_t pop_data
);
    import sco_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/sco_back.sv
// back end: accumulates masks into the cell store and emits the glyph
module sco_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           entry_valid,
    input  sco_pkg::entry_t                entry,
    output logic                           entry_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sco_pkg::GLYPH_BITS-1:0] cell_bits,
    output logic                           cell_empty
);
    import sco_pkg::*;

    logic [GLYPH_BITS-1:0] store_reg;
    logic [GLYPH_BITS-1:0] store_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [GLYPH_BITS-1:0] bits_reg;
    logic                  empty_reg;
    logic                  out_free;
    logic                  emit;

    // a last request needs the output register free or draining
    assign out_free  = !out_valid_reg || out_ready;
    assign entry_pop = entry_valid && (!entry.last || out_free);
    assign emit      = entry_pop && entry.last;

    assign store_next     = (entry.first ? '0 : store_reg) | entry.mask;
    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (entry_pop)
            begin
                store_reg <= store_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            bits_reg  <= store_next;
            empty_reg <= (store_next == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_bits  = bits_reg;
    assign cell_empty = empty_reg;

endmodule

// File: rtl/sprite_cell_compositor.sv
// top level of the sprite cell compositor
// an accepted request is queued, and a last one then loads the output register
// throughput: one request per cycle unless the queue is full; the two-entry queue
//   and output register let input flow while a finished glyph waits to be taken
// reset: the cell store clears to zero and the queue and output empty at once
module sprite_cell_compositor #(
    parameter int MAX_CELL_COLS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           first,
    input  logic                           last,
    input  logic [sco_pkg::ROW_BITS-1:0]   cell_row,
    input  logic [sco_pkg::COL_BITS-1:0]   cell_col,
    input  logic signed [8:0]              pos_x,
    input  logic signed [7:0]              pos_y,
    input  logic [sco_pkg::GLYPH_BITS-1:0] sprite_bits,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sco_pkg::GLYPH_BITS-1:0] cell_bits,
    output logic                           cell_empty
);
    import sco_pkg::*;

    entry_t front_entry;
    entry_t queue_entry;
    logic   queue_full;
    logic   queue_valid;
    logic   queue_pop;

    // classify the request
    sco_front #(
        .MAX_CELL_COLS (MAX_CELL_COLS)
    ) u_front (
        .first       (first),
        .last        (last),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .sprite_bits (sprite_bits),
        .entry       (front_entry)
    );

    assign in_ready = !queue_full;

    // decouple front and back
    sco_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_data (front_entry),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_data  (queue_entry)
    );

    // accumulate and emit
    sco_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (queue_valid),
        .entry       (queue_entry),
        .entry_pop   (queue_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_bits   (cell_bits),
        .cell_empty  (cell_empty)
    );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the sprite cell compositor
module tb_top;

    import sco_pkg::*;

    localparam int MAX_COLS = 32;

    // one sprite request, with an optional hand-typed glyph for simple rows
    typedef struct {
        logic                  first;
        logic                  last;
        logic [ROW_BITS-1:0]   crow;
        logic [COL_BITS-1:0]   ccol;
        logic signed [8:0]     px;
        logic signed [7:0]     py;
        logic [GLYPH_BITS-1:0] bits;
        bit                    typed;
        logic [GLYPH_BITS-1:0] glyph;
        logic                  empty;
    } sprite_req_t;

    typedef struct {
        logic [GLYPH_BITS-1:0] glyph;
        logic                  empty;
    } glyph_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  first = 1'b0;
    logic                  last = 1'b0;
    logic [ROW_BITS-1:0]   cell_row = '0;
    logic [COL_BITS-1:0]   cell_col = '0;
    logic signed [8:0]     pos_x = '0;
    logic signed [7:0]     pos_y = '0;
    logic [GLYPH_BITS-1:0] sprite_bits = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [GLYPH_BITS-1:0] cell_bits;
    logic                  cell_empty;

    // model state and the glyphs still owed by the block
    logic [GLYPH_BITS-1:0] composed_glyph = '0;
    glyph_t                glyph_q[$];
    int                    mismatches = 0;
    int                    sprites_sent = 0;
    int                    glyphs_seen = 0;
    int                    empty_glyphs = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_left = 0;
    sprite_req_t           plan[20];

    sprite_cell_compositor #(
        .MAX_CELL_COLS(MAX_COLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .first(first),
        .last(last),
        .cell_row(cell_row),
        .cell_col(cell_col),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .sprite_bits(sprite_bits),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cell_bits(cell_bits),
        .cell_empty(cell_empty)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // pixels of one sprite that fall inside the glyph area of the target cell
    function automatic logic [GLYPH_BITS-1:0] cell_pixels(
        input logic [ROW_BITS-1:0] crow,
        input logic [COL_BITS-1:0] ccol,
        input logic signed [8:0]   px,
        input logic signed [7:0]   py,
        input logic [GLYPH_BITS-1:0] bits
    );
        logic [GLYPH_BITS-1:0] acc;
        int x;
        int y;
        int gr;
        int gc;
        acc = '0;
        if (int'(ccol) >= MAX_COLS)
            return acc;
        for (int i = 0; i < GLYPH_ROWS; i++)
        begin
            for (int j = 0; j < GLYPH_COLS; j++)
            begin
                x = int'(px) + j;
                y = int'(py) + i;
                // off-screen pixels and pixels of other cells are dropped
                if (x < 0 || y < 0)
                    continue;
                if (x / PITCH_X != int'(ccol) || y / PITCH_Y != int'(crow))
                    continue;
                gc = x % PITCH_X;
                gr = y % PITCH_Y;
                // gap column and gap row belong to no glyph
                if (gr >= GLYPH_ROWS || gc >= GLYPH_COLS)
                    continue;
                if (bits[i * GLYPH_COLS + (GLYPH_COLS - 1 - j)])
                    acc[gr * GLYPH_COLS + (GLYPH_COLS - 1 - gc)] = 1'b1;
            end
        end
        return acc;
    endfunction

    // update the composed glyph for an accepted request and queue its output
    task automatic note_accepted(input sprite_req_t r);
        glyph_t g;
        if (r.first)
            composed_glyph = '0;
        composed_glyph |= cell_pixels(r.crow, r.ccol, r.px, r.py, r.bits);
        sprites_sent++;
        if (r.last)
        begin
            g.glyph = r.typed ? r.glyph : composed_glyph;
            g.empty = r.typed ? r.empty : (composed_glyph == '0);
            glyph_q.push_back(g);
        end
    endtask

    // offer one request after a random gap and wait for the handshake
    task automatic offer_sprite(input sprite_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        first       <= r.first;
        last        <= r.last;
        cell_row    <= r.crow;
        cell_col    <= r.ccol;
        pos_x       <= r.px;
        pos_y       <= r.py;
        sprite_bits <= r.bits;
        do
            @(posedge clk);
        while (!in_ready);
        note_accepted(r);
    endtask

    // sprite placed around the given cell so that most pixels land in it
    function automatic sprite_req_t near_sprite(input logic [ROW_BITS-1:0] crow,
                                                input logic [COL_BITS-1:0] ccol,
                                                input logic head, input logic tail);
        sprite_req_t r;
        logic [GLYPH_BITS-1:0] mask;
        r.first = head;
        r.last  = tail;
        r.crow  = crow;
        r.ccol  = ccol;
        r.px    = 9'(int'(ccol) * PITCH_X + $urandom_range(12) - 6);
        r.py    = 8'(int'(crow) * PITCH_Y + $urandom_range(18) - 9);
        r.bits  = GLYPH_BITS'({$urandom, $urandom});
        // sparse sprites now and then so glyphs show distinct shapes
        if ($urandom_range(3) == 0)
        begin
            mask   = GLYPH_BITS'({$urandom, $urandom});
            r.bits = r.bits & mask;
        end
        if ($urandom_range(15) == 0)
            r.bits = '0;
        r.typed = 1'b0;
        r.glyph = '0;
        r.empty = 1'b0;
        return r;
    endfunction

    // mostly well-formed first..last groups on one cell, some noise and broken groups
    task automatic run_random(input int count);
        sprite_req_t r;
        int sent;
        int len;
        logic [ROW_BITS-1:0] crow;
        logic [COL_BITS-1:0] ccol;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                len  = $urandom_range(1, 6);
                crow = ROW_BITS'($urandom);
                ccol = COL_BITS'($urandom);
                for (int k = 0; k < len; k++)
                begin
                    r = near_sprite(crow, ccol, k == 0, k == len - 1);
                    // broken group: missing first or a stray first mid-way
                    if ($urandom_range(19) == 0)
                        r.first = ~r.first;
                    offer_sprite(r);
                    sent++;
                end
            end
            else
            begin
                r = near_sprite(ROW_BITS'($urandom), COL_BITS'($urandom), 1'b0, 1'b0);
                r.first = 1'($urandom);
                r.last  = 1'($urandom);
                r.px    = 9'($urandom);
                r.py    = 8'($urandom);
                offer_sprite(r);
                sent++;
            end
        end
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare every glyph taken from the block with the oldest expectation
    always @(posedge clk)
    begin
        glyph_t g;
        if (rst_n && out_valid && out_ready)
        begin
            if (glyph_q.size() == 0)
            begin
                $display("%0t: unexpected glyph cell_bits=%h cell_empty=%b",
                         $time, cell_bits, cell_empty);
                mismatches++;
            end
            else
            begin
                g = glyph_q.pop_front();
                glyphs_seen++;
                if (g.empty)
                    empty_glyphs++;
                if (cell_bits !== g.glyph)
                begin
                    $display("%0t: cell_bits expected %h actual %h",
                             $time, g.glyph, cell_bits);
                    mismatches++;
                end
                if (cell_empty !== g.empty)
                begin
                    $display("%0t: cell_empty expected %b actual %b",
                             $time, g.empty, cell_empty);
                    mismatches++;
                end
            end
        end
    end

    // directed rows: typed glyph where it is obvious, predictor elsewhere
    initial
    begin
        plan[0]  = '{1'b0, 1'b1, 2'd0, 5'd0, 9'sd100, 8'sd100, {40{1'b1}},
                     1'b1, 40'h0, 1'b1};
        plan[1]  = '{1'b1, 1'b1, 2'd0, 5'd0, 9'sd0, 8'sd0, {40{1'b1}},
                     1'b1, {40{1'b1}}, 1'b0};
        plan[2]  = '{1'b1, 1'b1, 2'd3, 5'd31, 9'sd186, 8'sd27, {40{1'b1}},
                     1'b1, {40{1'b1}}, 1'b0};
        plan[3]  = '{1'b1, 1'b1, 2'd0, 5'd0, -9'sd1, -8'sd1, {40{1'b1}},
                     1'b0, 40'h0, 1'b0};
        plan[4]  = '{1'b1, 1'b1, 2'd0, 5'd0, -9'sd256, -8'sd128, {40{1'b1}},
                     1'b1, 40'h0, 1'b1};
        plan[5]  = '{1'b1, 1'b1, 2'd3, 5'd31, 9'sd255, 8'sd127, {40{1'b1}},
                     1'b1, 40'h0, 1'b1};
        plan[6]  = '{1'b1, 1'b1, 2'd0, 5'd0, 9'sd0, 8'sd0, 40'h0,
                     1'b1, 40'h0, 1'b1};
        plan[7]  = '{1'b1, 1'b0, 2'd1, 5'd2, 9'sd12, 8'sd9, 40'h1,
                     1'b0, 40'h0, 1'b0};
        plan[8]  = '{1'b0, 1'b0, 2'd1, 5'd2, 9'sd14, 8'sd12, 40'h12_3456_789a,
                     1'b0, 40'h0, 1'b0};
        plan[9]  = '{1'b0, 1'b1, 2'd1, 5'd2, 9'sd10, 8'sd16, 40'hff_0000_00ff,
                     1'b0, 40'h0, 1'b0};
        plan[10] = '{1'b0, 1'b0, 2'd0, 5'd0, 9'sd0, 8'sd0, {40{1'b1}},
                     1'b0, 40'h0, 1'b0};
        plan[11] = '{1'b1, 1'b1, 2'd0, 5'd0, 9'sd0, 8'sd0, 40'h0,
                     1'b1, 40'h0, 1'b1};
        plan[12] = '{1'b1, 1'b1, 2'd0, 5'd0, 9'sd1, 8'sd0, {40{1'b1}},
                     1'b0, 40'h0, 1'b0};
        plan[13] = '{1'b1, 1'b1, 2'd0, 5'd0, 9'sd0, 8'sd1, {40{1'b1}},
                     1'b0, 40'h0, 1'b0};
        plan[14] = '{1'b1, 1'b1, 2'd0, 5'd1, 9'sd3, 8'sd0, 40'hab_cdef_0123,
                     1'b0, 40'h0, 1'b0};
        plan[15] = '{1'b1, 1'b1, 2'd1, 5'd0, 9'sd0, 8'sd5, 40'h98_7654_3210,
                     1'b0, 40'h0, 1'b0};
        plan[16] = '{1'b1, 1'b1, 2'd0, 5'd0, 9'sd0, 8'sd0, 40'haa_aaaa_aaaa,
                     1'b1, 40'haa_aaaa_aaaa, 1'b0};
        plan[17] = '{1'b1, 1'b1, 2'd0, 5'd0, 9'sd0, 8'sd0, 40'h55_5555_5555,
                     1'b1, 40'h55_5555_5555, 1'b0};
        plan[18] = '{1'b1, 1'b1, 2'd0, 5'd31, 9'sd255, -8'sd128, {40{1'b1}},
                     1'b1, 40'h0, 1'b1};
        plan[19] = '{1'b1, 1'b1, 2'd3, 5'd0, 9'sd0, 8'sd127, {40{1'b1}},
                     1'b1, 40'h0, 1'b1};

        // reset once at the start
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at full rate on both sides
        foreach (plan[n])
            offer_sprite(plan[n]);

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 34;
        recv_idle_pct = 66;
        run_random(550);

        // receiver mostly ready, sender sparse; pause until the block drains
        send_idle_pct = 66;
        recv_idle_pct = 34;
        run_random(250);
        in_valid <= 1'b0;
        wait (glyph_q.size() == 0);
        repeat (4) @(posedge clk);
        run_random(300);

        // no idling; receiver holds off while single-item glyphs pile up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 80;
        for (int k = 0; k < 30; k++)
            offer_sprite(near_sprite(ROW_BITS'($urandom), COL_BITS'($urandom), 1'b1, 1'b1));
        run_random(520);
        in_valid <= 1'b0;

        // drain, then allow for the pipeline latency
        wait (glyph_q.size() == 0);
        repeat (10) @(posedge clk);
        $display("sprite requests accepted: %0d, glyphs checked: %0d (%0d empty)",
                 sprites_sent, glyphs_seen, empty_glyphs);
        $display("covered clipping, gap rows/columns, cell crossings and back-pressure");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hard limit on run time
    initial
    begin
        #2000000;
        $display("timeout: %0d glyphs still expected", glyph_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
